@@ hw/rtl/ubs_pkg.sv @@
package ubs_pkg;

    // Built size of the solver and fixed-point format
    localparam int MAX_SIZE  = 16;
    localparam int FRAC_BITS = 16;

    // Widths that follow from the built size
    localparam int IDX_W   = $clog2(MAX_SIZE);
    localparam int COEF_AW = $clog2(MAX_SIZE * MAX_SIZE);

    // Field widths of the channels
    localparam int REQ_W  = 2;
    localparam int ROW_W  = 6;
    localparam int SIZE_W = 7;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 2 * VAL_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_COEF = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_RHS  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SOLVE     = 2'd2;

    // Round half up: add half an LSB of the result before the shift
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        (PROD_W'(1) << FRAC_BITS) >> 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             ld_coef;    // write load value to the coefficient store
        logic             ld_rhs;     // write load value to the rhs store
        logic             clr_marks;  // clear all saturation marks
        logic             rd_emit;    // read rhs[row] as the final unknown
        logic             rd_upd;     // read rhs[row] and A[row][col] for an update
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } ubs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_full;   // result register holds a beat not yet taken
        logic pipe_busy;  // update pipeline still has writes in flight
    } ubs_status_t;

    function automatic logic [COEF_AW-1:0] coef_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        coef_addr = COEF_AW'(row) * COEF_AW'(MAX_SIZE) + COEF_AW'(col);
    endfunction

endpackage

@@ hw/rtl/ubs_if.sv @@
interface ubs_req_if;
    logic                           valid;
    logic                           ready;
    logic [ubs_pkg::REQ_W-1:0]      req_type;
    logic [ubs_pkg::ROW_W-1:0]      row_index;
    logic [ubs_pkg::ROW_W-1:0]      col_index;
    logic signed [ubs_pkg::VAL_W-1:0] load_value;

    modport source (output valid, req_type, row_index, col_index, load_value, input ready);
    modport sink   (input valid, req_type, row_index, col_index, load_value, output ready);
endinterface

interface ubs_res_if;
    logic                           valid;
    logic                           ready;
    logic [ubs_pkg::ROW_W-1:0]      unknown_index;
    logic signed [ubs_pkg::VAL_W-1:0] solution_value;
    logic                           saturated;
    logic                           last_result;

    modport source (output valid, unknown_index, solution_value, saturated, last_result,
                    input ready);
    modport sink   (input valid, unknown_index, solution_value, saturated, last_result,
                    output ready);
endinterface

interface ubs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ubs_pkg::SIZE_W-1:0]  system_size;

    modport source (output valid, system_size, input ready);
    modport sink   (input valid, system_size, output ready);
endinterface

@@ hw/rtl/ubs_ctrl.sv @@
module ubs_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [ubs_pkg::REQ_W-1:0]    req_type,
    input  logic [ubs_pkg::ROW_W-1:0]    row_index,
    input  logic [ubs_pkg::ROW_W-1:0]    col_index,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ubs_pkg::SIZE_W-1:0]   cfg_size,
    input  ubs_pkg::ubs_status_t         status,
    output ubs_pkg::ubs_cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_UPD
    } state_t;

    state_t                        state_reg, state_next;
    logic [ubs_pkg::IDX_W-1:0]     i_reg, i_next;
    logic [ubs_pkg::IDX_W-1:0]     r_reg, r_next;
    logic [ubs_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [ubs_pkg::IDX_W-1:0]     top_row;
    logic                          accept;
    logic                          row_ok;
    logic                          col_ok;
    logic                          emit_go;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = req_valid && req_ready;
    assign row_ok    = {1'b0, row_index} < ubs_pkg::SIZE_W'(ubs_pkg::MAX_SIZE);
    assign col_ok    = {1'b0, col_index} < ubs_pkg::SIZE_W'(ubs_pkg::MAX_SIZE);
    assign emit_go   = (state_reg == ST_EMIT) && !status.out_full && !status.pipe_busy;

    // Highest row of the run: size clipped to 1..MAX_SIZE, minus one
    always_comb
    begin
        priority if (size_reg == '0)
            top_row = '0;
        else if (size_reg > ubs_pkg::SIZE_W'(ubs_pkg::MAX_SIZE))
            top_row = ubs_pkg::IDX_W'(ubs_pkg::MAX_SIZE - 1);
        else
            top_row = ubs_pkg::IDX_W'(size_reg - ubs_pkg::SIZE_W'(1));
    end

    always_comb
    begin
        cmd.ld_coef   = accept && (req_type == ubs_pkg::REQ_LOAD_COEF) && row_ok && col_ok;
        cmd.ld_rhs    = accept && (req_type == ubs_pkg::REQ_LOAD_RHS) && row_ok;
        cmd.clr_marks = accept && (req_type == ubs_pkg::REQ_SOLVE);
        cmd.rd_emit   = emit_go;
        cmd.rd_upd    = (state_reg == ST_UPD);
        cmd.row       = (state_reg == ST_UPD) ? r_reg : i_reg;
        cmd.col       = i_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        r_next     = r_reg;
        size_next  = cfg_valid ? cfg_size : size_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == ubs_pkg::REQ_SOLVE))
                begin
                    i_next     = top_row;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    r_next     = '0;
                    state_next = (i_reg == '0) ? ST_IDLE : ST_UPD;
                end
            end
            ST_UPD:
            begin
                // Last lower row of this column: step to the next unknown
                if (r_reg == i_reg - ubs_pkg::IDX_W'(1))
                begin
                    i_next     = i_reg - ubs_pkg::IDX_W'(1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    r_next = r_reg + ubs_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            r_reg     <= '0;
            size_reg  <= ubs_pkg::SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            r_reg     <= r_next;
            size_reg  <= size_next;
        end
    end

endmodule

@@ hw/rtl/ubs_dp.sv @@
module ubs_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ubs_pkg::ubs_cmd_t                 cmd,
    output ubs_pkg::ubs_status_t              status,
    input  logic [ubs_pkg::ROW_W-1:0]         row_index,
    input  logic [ubs_pkg::ROW_W-1:0]         col_index,
    input  logic signed [ubs_pkg::VAL_W-1:0]  load_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [ubs_pkg::ROW_W-1:0]         unknown_index,
    output logic signed [ubs_pkg::VAL_W-1:0]  solution_value,
    output logic                              saturated,
    output logic                              last_result
);

    localparam int VW = ubs_pkg::VAL_W;
    localparam int PW = ubs_pkg::PROD_W;
    localparam int IW = ubs_pkg::IDX_W;

    logic signed [VW-1:0]  coef_mem [ubs_pkg::MAX_SIZE*ubs_pkg::MAX_SIZE];
    logic signed [VW-1:0]  rhs_mem  [ubs_pkg::MAX_SIZE];

    logic signed [VW-1:0]  coef_q_reg;
    logic signed [VW-1:0]  rhs_q_reg;
    logic                  s1_upd_reg;
    logic                  s1_emit_reg;
    logic [IW-1:0]         s1_row_reg;
    logic                  s2_v_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [VW-1:0]  s2_rhs_reg;
    logic [IW-1:0]         s2_row_reg;
    logic                  s3_v_reg;
    logic signed [PW-1:0]  q_reg;
    logic signed [VW-1:0]  s3_rhs_reg;
    logic [IW-1:0]         s3_row_reg;
    logic [ubs_pkg::MAX_SIZE-1:0] marks_reg;
    logic                  out_v_reg;
    logic [IW-1:0]         out_idx_reg;
    logic signed [VW-1:0]  out_val_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;

    logic signed [PW:0]    diff;
    logic                  sat;
    logic signed [VW-1:0]  upd_val;
    logic [IW-1:0]         rhs_waddr;
    logic signed [VW-1:0]  rhs_wdata;

    // Saturate when the upper bits are not a plain sign extension
    always_comb
    begin
        diff    = {{(PW-VW+1){s3_rhs_reg[VW-1]}}, s3_rhs_reg} - {q_reg[PW-1], q_reg};
        sat     = !((&diff[PW:VW-1]) || !(|diff[PW:VW-1]));
        upd_val = sat ? (diff[PW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                      : diff[VW-1:0];
    end

    always_comb
    begin
        if (cmd.ld_rhs)
        begin
            rhs_waddr = row_index[IW-1:0];
            rhs_wdata = load_value;
        end
        else
        begin
            rhs_waddr = s3_row_reg;
            rhs_wdata = upd_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_coef)
            coef_mem[ubs_pkg::coef_addr(row_index[IW-1:0], col_index[IW-1:0])] <= load_value;
        if (cmd.rd_upd)
            coef_q_reg <= coef_mem[ubs_pkg::coef_addr(cmd.row, cmd.col)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_rhs || s3_v_reg)
            rhs_mem[rhs_waddr] <= rhs_wdata;
        if (cmd.rd_emit || cmd.rd_upd)
            rhs_q_reg <= rhs_mem[cmd.row];
    end

    // Update pipeline payload and result payload
    always_ff @(posedge clk)
    begin
        s1_row_reg <= cmd.row;
        prod_reg   <= PW'(coef_q_reg) * PW'(out_val_reg);
        s2_rhs_reg <= rhs_q_reg;
        s2_row_reg <= s1_row_reg;
        q_reg      <= (prod_reg + ubs_pkg::ROUND_HALF) >>> ubs_pkg::FRAC_BITS;
        s3_rhs_reg <= s2_rhs_reg;
        s3_row_reg <= s2_row_reg;
        if (s1_emit_reg)
        begin
            out_idx_reg  <= s1_row_reg;
            out_val_reg  <= rhs_q_reg;
            out_sat_reg  <= marks_reg[s1_row_reg];
            out_last_reg <= (s1_row_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_upd_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            marks_reg   <= '0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            s1_upd_reg  <= cmd.rd_upd;
            s1_emit_reg <= cmd.rd_emit;
            s2_v_reg    <= s1_upd_reg;
            s3_v_reg    <= s2_v_reg;
            if (cmd.clr_marks)
                marks_reg <= '0;
            else if (s3_v_reg && sat)
                marks_reg[s3_row_reg] <= 1'b1;
            if (s1_emit_reg)
                out_v_reg <= 1'b1;
            else if (res_ready)
                out_v_reg <= 1'b0;
        end
    end

    assign status.out_full  = out_v_reg;
    assign status.pipe_busy = s1_upd_reg || s2_v_reg || s3_v_reg;

    assign res_valid      = out_v_reg;
    assign unknown_index  = ubs_pkg::ROW_W'(out_idx_reg);
    assign solution_value = out_val_reg;
    assign saturated      = out_sat_reg;
    assign last_result    = out_last_reg;

endmodule

@@ hw/rtl/unit_upper_back_substitution.sv @@
// Unit upper-triangular back substitution, signed Q16.16.
//
// Channels: req takes load and solve beats, res gives one beat per solved
// unknown, cfg writes system_size (taken at once; the user must write it only
// while idle, the block does not enforce this). req accepts a beat every
// cycle while idle. Coefficient loads with a row or column beyond the built
// size, rhs loads with a row beyond it, and unknown request codes are dropped.
// A solve emits unknowns from n-1 down to 0, last_result set on index 0.
// Per unknown i the block reads it, issues the row updates through the single
// multiply pipeline, and lets that pipeline drain before the next read.
// req is low for the whole solve.
// A result sits in an output register; when res stalls, the block keeps
// working on the rows below and holds before emitting the next unknown.
// Reset clears control state, the saturation marks and sets system_size to
// 16; the coefficient and rhs stores hold anything until loaded.
module unit_upper_back_substitution
(
    input  logic      clk,
    input  logic      rst_n,
    ubs_req_if.sink   req,
    ubs_res_if.source res,
    ubs_cfg_if.sink   cfg
);

    ubs_pkg::ubs_cmd_t    cmd;
    ubs_pkg::ubs_status_t status;

    // Sequencer: request decode, row and column counters, size register
    ubs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_type  (req.req_type),
        .row_index (req.row_index),
        .col_index (req.col_index),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_size  (cfg.system_size),
        .status    (status),
        .cmd       (cmd)
    );

    // Stores, multiply-round-subtract pipeline and result register
    ubs_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .row_index      (req.row_index),
        .col_index      (req.col_index),
        .load_value     (req.load_value),
        .res_valid      (res.valid),
        .res_ready      (res.ready),
        .unknown_index  (res.unknown_index),
        .solution_value (res.solution_value),
        .saturated      (res.saturated),
        .last_result    (res.last_result)
    );

endmodule

@@ hw/rtl/ubs_checker.sv @@
module ubs_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic [ubs_pkg::REQ_W-1:0]         req_type,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [ubs_pkg::ROW_W-1:0]         res_index,
    input logic signed [ubs_pkg::VAL_W-1:0]  res_value,
    input logic                              res_last
);

    // Hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_index) && $stable(res_value))
        else $error("stalled result beat changed");

    // A solve takes the request channel away
    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == ubs_pkg::REQ_SOLVE) |=> !req_ready)
        else $error("request accepted right after a solve");

    // No new request while a solve still has unknowns to emit
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("request ready in the middle of a solve");

    // The last beat ends the run
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_last |=> !res_valid)
        else $error("result beat right after the last one");

endmodule

bind unit_upper_back_substitution ubs_checker u_ubs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_index (res.unknown_index),
    .res_value (res.solution_value),
    .res_last  (res.last_result)
);
